### src/omm_pkg.sv
`timescale 1ns / 1ps
package omm_pkg;

   localparam int CORDIC_STEPS  = 24;
   localparam int FRACTION_BITS = 16;

   localparam int XY_W   = 34;                 // Q2.30 with headroom
   localparam int Z_W    = 33;
   localparam int TRIG_W = FRACTION_BITS + 2;  // signed Q1.F plus headroom
   localparam int TRIG_SH = 30 - FRACTION_BITS;
   localparam int LAT    = CORDIC_STEPS + 5;   // phase, cordic, 3 matrix stages

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

   typedef enum logic [2:0] {
      REG_ORBIT_OFFSET = 3'd0,
      REG_ORBIT_VEL    = 3'd1,
      REG_ORBIT_RADIUS = 3'd2,
      REG_ORBIT_INCL   = 3'd3,
      REG_SPIN_VEL     = 3'd4,
      REG_AXIAL_TILT   = 3'd5,
      REG_BODY_SIZE    = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic [31:0] orbit_offset;
      logic [31:0] orbit_velocity;
      logic [30:0] orbit_radius;
      logic [31:0] orbit_inclination;
      logic [31:0] spin_velocity;
      logic [31:0] axial_tilt;
      logic [23:0] body_size;
   } cfg_type;

   function automatic logic signed [Z_W-1:0] atan_val(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
         3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
         9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
         12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2F9;
         15: v = 32'h0000517C; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
         18: v = 32'h00000A2F; 19: v = 32'h00000517; 20: v = 32'h0000028B;
         21: v = 32'h00000145; 22: v = 32'h000000A2; 23: v = 32'h00000051;
         24: v = 32'h00000028; 25: v = 32'h00000014; 26: v = 32'h0000000A;
         27: v = 32'h00000005; 28: v = 32'h00000002; 29: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return $signed({1'b0, v});
   endfunction

   // round half up by FRACTION_BITS
   function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
      return (v + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### src/omm_phase.sv
`timescale 1ns / 1ps
module omm_phase (
   input  logic                 clock,
   input  logic                 en,
   input  omm_pkg::cfg_type     cfg,
   input  logic [31:0]          time_ticks,
   output logic [31:0]          orbit_ph,
   output logic [31:0]          spin_ph,
   output logic [31:0]          incl_ph,
   output logic [31:0]          tilt_ph
);
   logic [31:0] orbit_ph_ff, orbit_ph_in;
   logic [31:0] spin_ph_ff, spin_ph_in;
   logic [31:0] incl_ph_ff, tilt_ph_ff;

   always_comb begin
      orbit_ph_in = 32'd0 - (cfg.orbit_offset + cfg.orbit_velocity * time_ticks);
      spin_ph_in  = cfg.spin_velocity * time_ticks;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         orbit_ph_ff <= orbit_ph_in;
         spin_ph_ff  <= spin_ph_in;
         incl_ph_ff  <= cfg.orbit_inclination;
         tilt_ph_ff  <= cfg.axial_tilt;
      end
   end

   assign orbit_ph = orbit_ph_ff;
   assign spin_ph  = spin_ph_ff;
   assign incl_ph  = incl_ph_ff;
   assign tilt_ph  = tilt_ph_ff;
endmodule

### src/omm_cordic.sv
`timescale 1ns / 1ps
module omm_cordic (
   input  logic                                clock,
   input  logic                                en,
   input  logic [31:0]                         ang,
   output logic signed [omm_pkg::TRIG_W-1:0]   cos_o,
   output logic signed [omm_pkg::TRIG_W-1:0]   sin_o
);
   localparam int N = omm_pkg::CORDIC_STEPS;

   logic signed [omm_pkg::XY_W-1:0] x_ff [N];
   logic signed [omm_pkg::XY_W-1:0] y_ff [N];
   logic signed [omm_pkg::Z_W-1:0]  z_ff [N];
   logic [1:0]                      q_ff [N];

   logic signed [omm_pkg::XY_W-1:0] cv, sv, cr, sr;
   logic signed [omm_pkg::TRIG_W-1:0] cos_ff, sin_ff;

   for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [omm_pkg::XY_W-1:0] xp, yp;
      logic signed [omm_pkg::Z_W-1:0]  zp;
      logic [1:0]                      qp;
      logic signed [omm_pkg::XY_W-1:0] x_in, y_in;
      logic signed [omm_pkg::Z_W-1:0]  z_in;
      if (i == 0) begin : g_first
         assign xp = omm_pkg::CORDIC_GAIN;
         assign yp = '0;
         assign zp = $signed({3'b000, ang[29:0]});
         assign qp = ang[31:30];
      end else begin : g_rest
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign qp = q_ff[i-1];
      end
      always_comb begin
         if (!zp[omm_pkg::Z_W-1]) begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = zp - omm_pkg::atan_val(i);
         end else begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = zp + omm_pkg::atan_val(i);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
            q_ff[i] <= qp;
         end
      end
   end

   // quadrant fold, then round to Q.F
   always_comb begin
      case (q_ff[N-1])
         2'd0: begin cv = x_ff[N-1];  sv = y_ff[N-1];  end
         2'd1: begin cv = -y_ff[N-1]; sv = x_ff[N-1];  end
         2'd2: begin cv = -x_ff[N-1]; sv = -y_ff[N-1]; end
         default: begin cv = y_ff[N-1]; sv = -x_ff[N-1]; end
      endcase
      cr = (cv + (omm_pkg::XY_W'(1) <<< (omm_pkg::TRIG_SH - 1))) >>> omm_pkg::TRIG_SH;
      sr = (sv + (omm_pkg::XY_W'(1) <<< (omm_pkg::TRIG_SH - 1))) >>> omm_pkg::TRIG_SH;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cr[omm_pkg::TRIG_W-1:0];
         sin_ff <= sr[omm_pkg::TRIG_W-1:0];
      end
   end

   assign cos_o = cos_ff;
   assign sin_o = sin_ff;
endmodule

### src/omm_matrix.sv
`timescale 1ns / 1ps
module omm_matrix (
   input  logic                                clock,
   input  logic                                en,
   input  omm_pkg::cfg_type                    cfg,
   input  logic signed [omm_pkg::TRIG_W-1:0]   ca, sa, ci, si, cs, ss, ct, st,
   output logic signed [31:0]                  a00, a01, a02,
   output logic signed [31:0]                  a10, a11, a12,
   output logic signed [31:0]                  a20, a21, a22,
   output logic signed [31:0]                  pos_x, pos_y, pos_z
);
   localparam int T = omm_pkg::TRIG_W;

   logic signed [24:0] sz;
   logic signed [31:0] r;
   assign sz = $signed({1'b0, cfg.body_size});
   assign r  = $signed({1'b0, cfg.orbit_radius});

   // stage 1: raw products
   logic signed [2*T-1:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [T+24:0]   s02_ff, s12_ff, s20_ff, s21_ff;
   logic signed [T+31:0]   ru_ff, rw_ff;
   logic signed [T-1:0]    ci1_ff, si1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= ct * cs;
         p01_ff <= ct * ss;
         p10_ff <= st * cs;
         p11_ff <= st * ss;
         s02_ff <= -(st * sz);
         s12_ff <= ct * sz;
         s20_ff <= -(ss * sz);
         s21_ff <= -(cs * sz);
         ru_ff  <= r * ca;
         rw_ff  <= r * sa;
         ci1_ff <= ci;
         si1_ff <= si;
      end
   end

   // stage 2: round trig products, scale by size; incline the orbit
   logic signed [63:0] q00, q01, q10, q11, w;
   logic signed [63:0] m00_ff, m01_ff, m10_ff, m11_ff;
   logic signed [63:0] m02_ff, m12_ff, m20_ff, m21_ff;
   logic signed [63:0] u_ff, py_ff, pz_ff;

   always_comb begin
      q00 = omm_pkg::rnd(64'(p00_ff));
      q01 = omm_pkg::rnd(-64'(p01_ff));
      q10 = omm_pkg::rnd(64'(p10_ff));
      q11 = omm_pkg::rnd(-64'(p11_ff));
      w   = omm_pkg::rnd(64'(rw_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m00_ff <= $signed(q00[T:0]) * sz;
         m01_ff <= $signed(q01[T:0]) * sz;
         m10_ff <= $signed(q10[T:0]) * sz;
         m11_ff <= $signed(q11[T:0]) * sz;
         m02_ff <= 64'(s02_ff);
         m12_ff <= 64'(s12_ff);
         m20_ff <= 64'(s20_ff);
         m21_ff <= 64'(s21_ff);
         u_ff   <= omm_pkg::rnd(64'(ru_ff));
         py_ff  <= -(64'(si1_ff) * $signed(w[35:0]));
         pz_ff  <= 64'(ci1_ff) * $signed(w[35:0]);
      end
   end

   // stage 3: round and saturate into the output register
   logic signed [31:0] a00_ff, a01_ff, a02_ff, a10_ff, a11_ff, a12_ff;
   logic signed [31:0] a20_ff, a21_ff, x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a00_ff <= omm_pkg::sat32(omm_pkg::rnd(m00_ff));
         a01_ff <= omm_pkg::sat32(omm_pkg::rnd(m01_ff));
         a02_ff <= omm_pkg::sat32(omm_pkg::rnd(m02_ff));
         a10_ff <= omm_pkg::sat32(omm_pkg::rnd(m10_ff));
         a11_ff <= omm_pkg::sat32(omm_pkg::rnd(m11_ff));
         a12_ff <= omm_pkg::sat32(omm_pkg::rnd(m12_ff));
         a20_ff <= omm_pkg::sat32(omm_pkg::rnd(m20_ff));
         a21_ff <= omm_pkg::sat32(omm_pkg::rnd(m21_ff));
         x_ff   <= omm_pkg::sat32(u_ff);
         y_ff   <= omm_pkg::sat32(omm_pkg::rnd(py_ff));
         z_ff   <= omm_pkg::sat32(omm_pkg::rnd(pz_ff));
      end
   end

   assign a00 = a00_ff;  assign a01 = a01_ff;  assign a02 = a02_ff;
   assign a10 = a10_ff;  assign a11 = a11_ff;  assign a12 = a12_ff;
   assign a20 = a20_ff;  assign a21 = a21_ff;  assign a22 = '0;
   assign pos_x = x_ff;  assign pos_y = y_ff;  assign pos_z = z_ff;
endmodule

### src/orbit_model_matrix_top.sv
`timescale 1ns / 1ps
// Orbit model matrix: one time beat in, one 3x4 affine matrix beat out. The
// pipeline takes a beat every cycle unless stalled. Its stages are one
// phase multiply stage, one register per CORDIC iteration plus the quadrant
// and rounding stage, and three multiply/round/saturate stages. The whole pipe
// holds while a finished beat waits on rsp_ready. Write registers only while
// no beat is in flight.
module orbit_model_matrix_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_time_ticks,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_a00, rsp_a01, rsp_a02,
   output logic signed [31:0] rsp_a10, rsp_a11, rsp_a12,
   output logic signed [31:0] rsp_a20, rsp_a21, rsp_a22,
   output logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   localparam int L = omm_pkg::LAT;

   omm_pkg::cfg_type cfg_ff;
   logic [L-1:0]     vld_ff;
   logic             adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{body_size: 24'd65536, default: '0};
      end else if (csr_we) begin
         case (csr_index)
            omm_pkg::REG_ORBIT_OFFSET: cfg_ff.orbit_offset      <= csr_wdata;
            omm_pkg::REG_ORBIT_VEL:    cfg_ff.orbit_velocity    <= csr_wdata;
            omm_pkg::REG_ORBIT_RADIUS: cfg_ff.orbit_radius      <= csr_wdata[30:0];
            omm_pkg::REG_ORBIT_INCL:   cfg_ff.orbit_inclination <= csr_wdata;
            omm_pkg::REG_SPIN_VEL:     cfg_ff.spin_velocity     <= csr_wdata;
            omm_pkg::REG_AXIAL_TILT:   cfg_ff.axial_tilt        <= csr_wdata;
            omm_pkg::REG_BODY_SIZE:    cfg_ff.body_size         <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // hold everything while the output beat is stalled
   assign adv       = !vld_ff[L-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[L-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[L-2:0], req_valid};
      end
   end

   logic [31:0] orbit_ph, spin_ph, incl_ph, tilt_ph;
   logic signed [omm_pkg::TRIG_W-1:0] ca, sa, ci, si, cs, ss, ct, st;

   omm_phase u_phase (
      .clock(clock), .en(adv), .cfg(cfg_ff), .time_ticks(req_time_ticks),
      .orbit_ph(orbit_ph), .spin_ph(spin_ph), .incl_ph(incl_ph), .tilt_ph(tilt_ph)
   );

   omm_cordic u_cordic_orbit (.clock(clock), .en(adv), .ang(orbit_ph), .cos_o(ca), .sin_o(sa));
   omm_cordic u_cordic_incl  (.clock(clock), .en(adv), .ang(incl_ph),  .cos_o(ci), .sin_o(si));
   omm_cordic u_cordic_spin  (.clock(clock), .en(adv), .ang(spin_ph),  .cos_o(cs), .sin_o(ss));
   omm_cordic u_cordic_tilt  (.clock(clock), .en(adv), .ang(tilt_ph),  .cos_o(ct), .sin_o(st));

   omm_matrix u_matrix (
      .clock(clock), .en(adv), .cfg(cfg_ff),
      .ca(ca), .sa(sa), .ci(ci), .si(si), .cs(cs), .ss(ss), .ct(ct), .st(st),
      .a00(rsp_a00), .a01(rsp_a01), .a02(rsp_a02),
      .a10(rsp_a10), .a11(rsp_a11), .a12(rsp_a12),
      .a20(rsp_a20), .a21(rsp_a21), .a22(rsp_a22),
      .pos_x(rsp_pos_x), .pos_y(rsp_pos_y), .pos_z(rsp_pos_z)
   );

`ifndef SYNTH
   a_a22_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_a22 == 32'sd0) else $error("a22 not zero");

   a_no_radius : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cfg_ff.orbit_radius == '0 |->
         rsp_pos_x == 32'sd0 && rsp_pos_y == 32'sd0 && rsp_pos_z == 32'sd0)
      else $error("position nonzero at zero radius");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff)) else $error("pipe moved during stall");
`endif
endmodule
